/* hdl/dns_response_address_parser_assert.svh */
// Assertion macros shared by the DNS response address parser modules.
// No dependencies; each user includes this file inside its module body.
`ifndef DNS_RESPONSE_ADDRESS_PARSER_ASSERT_SVH
`define DNS_RESPONSE_ADDRESS_PARSER_ASSERT_SVH

// Property that must hold at every rising clock edge outside reset.
`define DRAP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define DRAP_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dnsrap_pkg.sv */
// Shared types and constants of the DNS response address parser.
// No dependencies; imported by the parser core, the output buffer and the top level.
package dnsrap_pkg;

    localparam logic [15:0] HEADER_BYTES = 16'd12;
    localparam logic [15:0] TAIL_BYTES   = 16'd4;
    localparam logic [15:0] RECORD_FIXED = 16'd12;
    localparam logic [15:0] ADDR_BYTES   = 16'd4;
    localparam logic [15:0] TYPE_A       = 16'd1;

    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic [31:0] address;
        logic        status;
    } t_result;

endpackage

/* hdl/dns_response_address_parser.sv */
// Top level of the DNS response address parser: input register, parser core, result buffer.
// Depends on dnsrap_pkg, dnsrap_parse and dnsrap_out_buf.
//
// Usage:
//   The input channel carries one byte of a DNS response per item, with
//   i_last_byte marking the final byte of the message. An item is taken at
//   a rising edge where i_valid is high and o_stall is low.
//   The output channel carries at most one result per message: either the
//   address of the first type-A answer (o_status low, first byte most
//   significant), or o_status high with a zero address when the message
//   ends without one. A result is taken where o_valid is high and i_stall
//   is low.
//   Throughput is one byte per cycle while the result buffer has space: each
//   byte is handled by the parser step between the input register and the result buffer.
//   A result reaches the outputs through the input register and the buffer:
//   the byte that causes it sits in the input register while the parser step
//   works on it, and the result is registered in the buffer at the next edge.
//   When the receiver stalls, results collect in a two-entry buffer; once
//   it is full the parser holds its byte and o_stall rises, so no result is
//   lost. The next message starts with the byte after a final byte.
//   Reset clears the parser state and empties both registers; no clearing
//   pass is needed and an item can be taken in the first cycle after reset.
module dns_response_address_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_address,
    output logic        o_status
);
    import dnsrap_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       buf_space;
    logic       take;
    logic       accept;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // The parser consumes the held byte only while the buffer can take a result.
    assign take    = r_in_valid && buf_space;
    assign o_stall = r_in_valid && !buf_space;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (take) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    dnsrap_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dnsrap_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_space (buf_space),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_address = out_res.address;
    assign o_status  = out_res.status;

endmodule

/* hdl/dnsrap_parse.sv */
// Message walker of the DNS response address parser: phase state and one step per byte.
// Depends on dnsrap_pkg and dns_response_address_parser_assert.svh.
module dnsrap_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_res_valid,
    output dnsrap_pkg::t_result o_res
);
    import dnsrap_pkg::*;

    localparam logic [2:0] PH_HEADER     = 3'd0;
    localparam logic [2:0] PH_LABEL_LEN  = 3'd1;
    localparam logic [2:0] PH_LABEL_SKIP = 3'd2;
    localparam logic [2:0] PH_TAIL       = 3'd3;
    localparam logic [2:0] PH_RECORD     = 3'd4;
    localparam logic [2:0] PH_RDATA      = 3'd5;
    localparam logic [2:0] PH_ADDR       = 3'd6;
    localparam logic [2:0] PH_DONE       = 3'd7;

    logic [2:0]  r_phase,    n_phase;
    logic [15:0] r_count,    n_count;
    logic [15:0] r_type,     n_type;
    logic [15:0] r_length,   n_length;
    logic [31:0] r_gather,   n_gather;
    logic        r_reported, n_reported;

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_type      = r_type;
        n_length    = r_length;
        n_gather    = r_gather;
        n_reported  = r_reported;
        o_res_valid = 1'b0;
        o_res       = '{address: 32'd0, status: STATUS_NOT_FOUND};
        if (i_take) begin
            case (r_phase)
                PH_HEADER: begin
                    n_count = r_count + 16'd1;
                    if (n_count >= HEADER_BYTES) begin
                        n_phase = PH_LABEL_LEN;
                        n_count = 16'd0;
                    end
                end
                PH_LABEL_LEN: begin
                    if (i_byte == 8'd0) begin
                        n_phase = PH_TAIL;
                        n_count = TAIL_BYTES;
                    end else begin
                        n_phase = PH_LABEL_SKIP;
                        n_count = {8'd0, i_byte};
                    end
                end
                PH_LABEL_SKIP: begin
                    n_count = r_count - 16'd1;
                    if (n_count == 16'd0) begin
                        n_phase = PH_LABEL_LEN;
                    end
                end
                PH_TAIL: begin
                    n_count = r_count - 16'd1;
                    if (n_count == 16'd0) begin
                        n_phase = PH_RECORD;
                    end
                end
                PH_RECORD: begin
                    if (r_count inside {16'd2, 16'd3}) begin
                        n_type = {r_type[7:0], i_byte};
                    end
                    if (r_count inside {16'd10, 16'd11}) begin
                        n_length = {r_length[7:0], i_byte};
                    end
                    n_count = r_count + 16'd1;
                    if (n_count >= RECORD_FIXED) begin
                        if (n_type == TYPE_A) begin
                            n_phase  = PH_ADDR;
                            n_count  = 16'd0;
                            n_gather = 32'd0;
                        end else if (n_length == 16'd0) begin
                            n_phase = PH_RECORD;
                            n_count = 16'd0;
                        end else begin
                            n_phase = PH_RDATA;
                            n_count = n_length;
                        end
                        n_type   = 16'd0;
                        n_length = 16'd0;
                    end
                end
                PH_RDATA: begin
                    n_count = r_count - 16'd1;
                    if (n_count == 16'd0) begin
                        n_phase = PH_RECORD;
                    end
                end
                PH_ADDR: begin
                    n_gather = {r_gather[23:0], i_byte};
                    n_count  = r_count + 16'd1;
                    if (n_count >= ADDR_BYTES) begin
                        o_res_valid = 1'b1;
                        o_res       = '{address: n_gather, status: STATUS_FOUND};
                        n_reported  = 1'b1;
                        n_phase     = PH_DONE;
                        n_count     = 16'd0;
                    end
                end
                default: begin
                end
            endcase
            if (i_last) begin
                // A message that ends without an address reports not-found once.
                if (!n_reported) begin
                    o_res_valid = 1'b1;
                    o_res       = '{address: 32'd0, status: STATUS_NOT_FOUND};
                end
                n_phase    = PH_HEADER;
                n_count    = 16'd0;
                n_type     = 16'd0;
                n_length   = 16'd0;
                n_gather   = 32'd0;
                n_reported = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_count    <= 16'd0;
            r_type     <= 16'd0;
            r_length   <= 16'd0;
            r_gather   <= 32'd0;
            r_reported <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_type     <= n_type;
            r_length   <= n_length;
            r_gather   <= n_gather;
            r_reported <= n_reported;
        end
    end

    `include "dns_response_address_parser_assert.svh"

    `DRAP_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, i_take && i_last, (r_phase == PH_HEADER) && (r_count == 16'd0) && !r_reported, "last byte did not restart the parser")
    `DRAP_ASSERT(a_found_from_addr, i_clk, i_rst_n, !(o_res_valid && (o_res.status == STATUS_FOUND)) || (r_phase == PH_ADDR), "found result outside the address phase")
    `DRAP_ASSERT(a_missing_on_last, i_clk, i_rst_n, !(o_res_valid && (o_res.status == STATUS_NOT_FOUND)) || (i_last && !r_reported), "not-found result without a final byte")

endmodule

/* hdl/dnsrap_out_buf.sv */
// Two-entry result buffer that decouples the parser from a stalling receiver.
// Depends on dnsrap_pkg and dns_response_address_parser_assert.svh.
module dnsrap_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dnsrap_pkg::t_result i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_stall,
    output dnsrap_pkg::t_result o_res
);
    import dnsrap_pkg::*;

    logic [1:0] r_count, n_count;
    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_res   = r_slot0;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (i_push && pop) begin
            if (r_count == 2'd1) begin
                n_slot0 = i_res;
            end else begin
                n_slot0 = r_slot1;
                n_slot1 = i_res;
            end
        end else if (i_push) begin
            n_count = r_count + 2'd1;
            if (r_count == 2'd0) begin
                n_slot0 = i_res;
            end else begin
                n_slot1 = i_res;
            end
        end else if (pop) begin
            n_count = r_count - 2'd1;
            n_slot0 = r_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    `include "dns_response_address_parser_assert.svh"

    `DRAP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count != 2'd3, "result buffer count out of range")
    `DRAP_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && (r_count == 2'd2)), "push into a full result buffer")
    `DRAP_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, i_push && (r_count == 2'd0), o_valid && (o_res == $past(i_res)), "pushed result not presented")

endmodule

/* sim/tb_top.sv */
// Self-checking testbench of dns_response_address_parser: DNS response messages in, one result out.
// Depends on dnsrap_pkg and the parser RTL; predicts results with its own model of the parser.
// Directed messages cover the special cases and random messages follow, under random idling.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dnsrap_pkg::*;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned CYCLE_LIMIT   = 100_000;
    // The result of a byte is registered in the result buffer when the parser takes
    // the byte; the drain wait lets any result that should not be there show up.
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned RANDOM_BYTES  = 100;
    localparam int unsigned RANDOM_RESULTS = 5;
    localparam int unsigned MAX_PRINTS    = 30;

    // Byte positions inside the fixed part of an answer record.
    localparam logic [15:0] TYPE_OFFSET   = 16'd2;
    localparam logic [15:0] LENGTH_OFFSET = 16'd10;

    typedef enum logic [2:0] {
        ST_HEADER, ST_LABEL_LEN, ST_LABEL_SKIP, ST_TAIL,
        ST_RECORD, ST_RDATA, ST_ADDR, ST_DONE
    } t_parse_stage;

    typedef enum logic [1:0] {RX_READY, RX_LIGHT, RX_HEAVY, RX_PATTERN} t_rx_mode;

    // Every input of the block has a known value from time zero.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_address;
    logic        o_status;

    dns_response_address_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_address   (o_address),
        .o_status    (o_status)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Copy of the parser state kept by the predictor.
    t_parse_stage stage;
    logic [15:0]  count;
    logic [15:0]  rtype;
    logic [15:0]  rlen;
    logic [31:0]  addr_acc;
    logic         reported;

    t_result      expected_results[$];
    logic [7:0]   msg[$];

    int unsigned  error_count    = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  results_seen   = 0;
    int unsigned  found_count    = 0;
    int unsigned  missing_count  = 0;
    int unsigned  bytes_sent     = 0;
    int unsigned  messages_sent  = 0;
    int unsigned  input_stalls   = 0;
    int unsigned  burst_left     = 0;
    bit           sender_gaps    = 1'b1;
    t_rx_mode     stall_mode     = RX_READY;
    int unsigned  hold_requests  = 0;
    int unsigned  hold_served    = 0;
    int unsigned  hold_left      = 0;
    int unsigned  rx_tick        = 0;

    // ------------------------------------------------------------------
    // Predictor: walks the message one byte at a time, like the parser.
    // ------------------------------------------------------------------
    function automatic void reset_prediction();
        stage    = ST_HEADER;
        count    = 16'd0;
        rtype    = 16'd0;
        rlen     = 16'd0;
        addr_acc = 32'd0;
        reported = 1'b0;
    endfunction

    function automatic void predict_address(input logic [7:0] b, input logic last);
        t_result r;
        case (stage)
            ST_HEADER: begin
                count = count + 16'd1;
                if (count >= HEADER_BYTES) begin
                    stage = ST_LABEL_LEN;
                    count = 16'd0;
                end
            end
            ST_LABEL_LEN: begin
                // A zero length closes the question name; anything else,
                // compression marks included, is a plain label length.
                if (b == 8'd0) begin
                    stage = ST_TAIL;
                    count = TAIL_BYTES;
                end else begin
                    stage = ST_LABEL_SKIP;
                    count = {8'd0, b};
                end
            end
            ST_LABEL_SKIP: begin
                count = count - 16'd1;
                if (count == 16'd0) stage = ST_LABEL_LEN;
            end
            ST_TAIL: begin
                count = count - 16'd1;
                if (count == 16'd0) stage = ST_RECORD;
            end
            ST_RECORD: begin
                if (count == TYPE_OFFSET || count == TYPE_OFFSET + 16'd1)
                    rtype = {rtype[7:0], b};
                if (count == LENGTH_OFFSET || count == LENGTH_OFFSET + 16'd1)
                    rlen = {rlen[7:0], b};
                count = count + 16'd1;
                if (count >= RECORD_FIXED) begin
                    if (rtype == TYPE_A) begin
                        // The data length of an A record is not looked at.
                        stage    = ST_ADDR;
                        count    = 16'd0;
                        addr_acc = 32'd0;
                    end else if (rlen == 16'd0) begin
                        stage = ST_RECORD;
                        count = 16'd0;
                    end else begin
                        stage = ST_RDATA;
                        count = rlen;
                    end
                    rtype = 16'd0;
                    rlen  = 16'd0;
                end
            end
            ST_RDATA: begin
                count = count - 16'd1;
                if (count == 16'd0) stage = ST_RECORD;
            end
            ST_ADDR: begin
                addr_acc = {addr_acc[23:0], b};
                count    = count + 16'd1;
                if (count >= ADDR_BYTES) begin
                    r.address = addr_acc;
                    r.status  = STATUS_FOUND;
                    expected_results.push_back(r);
                    reported = 1'b1;
                    stage    = ST_DONE;
                    count    = 16'd0;
                end
            end
            default: ;
        endcase

        // The final byte closes the message: report a miss if nothing was
        // found, then start over for the next message.
        if (last) begin
            if (!reported) begin
                r.address = 32'd0;
                r.status  = STATUS_NOT_FOUND;
                expected_results.push_back(r);
            end
            reset_prediction();
        end
    endfunction

    // ------------------------------------------------------------------
    // Message building.
    // ------------------------------------------------------------------
    function automatic void put_random(input int unsigned n);
        repeat (n) msg.push_back(8'($urandom));
    endfunction

    function automatic void put_label(input int unsigned len);
        msg.push_back(8'(len));
        put_random(len);
    endfunction

    function automatic void put_question_end();
        msg.push_back(8'h00);
        put_random(TAIL_BYTES);
    endfunction

    function automatic void put_record(input logic [15:0] kind, input logic [15:0] len);
        put_random(2);
        msg.push_back(kind[15:8]);
        msg.push_back(kind[7:0]);
        put_random(6);
        msg.push_back(len[15:8]);
        msg.push_back(len[7:0]);
        put_random(len);
    endfunction

    // An A record carries exactly four address bytes whatever its length field says.
    function automatic void put_a_record(input logic [31:0] addr, input logic [15:0] len);
        put_random(2);
        msg.push_back(TYPE_A[15:8]);
        msg.push_back(TYPE_A[7:0]);
        put_random(6);
        msg.push_back(len[15:8]);
        msg.push_back(len[7:0]);
        for (int k = 3; k >= 0; k--) msg.push_back(addr[8*k +: 8]);
    endfunction

    // Header, one 3-byte label, a 2-byte CNAME-like record, then the A record.
    // Positions: header 0..11, label 12..15, end 16, tail 17..20,
    // first record 21..34, A record 35..46, address 47..50.
    function automatic void build_sample_message(input logic [31:0] addr);
        msg.delete();
        put_random(HEADER_BYTES);
        put_label(3);
        put_question_end();
        put_record(16'h0005, 16'd2);
        put_a_record(addr, 16'd4);
    endfunction

    // ------------------------------------------------------------------
    // Input side: one item per call, in bursts with random gaps when sender_gaps is set.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        @(negedge i_clk);
        if (sender_gaps && burst_left == 0) begin
            gap = $urandom_range(0, 8);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 32);
        end
        i_valid     = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        do begin
            @(posedge i_clk);
            if (o_stall) input_stalls++;
        end while (o_stall);
        predict_address(b, last);
        bytes_sent++;
        if (burst_left != 0) burst_left--;
    endtask

    // Sends the message held in msg, cut short to the first cut bytes when
    // cut is nonzero; the last byte sent carries the final-byte mark.
    task automatic send_message(input int unsigned cut);
        int unsigned n;
        n = (cut == 0 || cut > msg.size()) ? msg.size() : cut;
        for (int unsigned k = 0; k < n; k++) send_byte(msg[k], k == n - 1);
        messages_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed responses with random content; the rest is noise
    // or messages cut off at a random byte.
    task automatic send_random_message();
        int unsigned kind;
        int unsigned nrec;
        int unsigned cut;
        logic [15:0] other;
        msg.delete();
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            put_random($urandom_range(1, 40));
            send_message(0);
            return;
        end
        put_random(HEADER_BYTES);
        repeat ($urandom_range(1, 4))
            put_label(($urandom_range(0, 19) == 0) ? $urandom_range(13, 255)
                                                    : $urandom_range(1, 12));
        put_question_end();
        nrec = $urandom_range(0, 3);
        for (int r = 0; r < nrec; r++) begin
            case ($urandom_range(0, 3))
                0:       other = 16'h0005;
                1:       other = 16'h0100;
                2:       other = 16'h001c;
                default: other = 16'($urandom);
            endcase
            put_record(other, ($urandom_range(0, 9) == 0) ? 16'($urandom_range(256, 300))
                                                          : 16'($urandom_range(0, 16)));
        end
        if ($urandom_range(0, 4) != 0)
            put_a_record($urandom, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd4);
        put_random($urandom_range(0, 6));
        cut = (kind < 40) ? $urandom_range(1, msg.size()) : 0;
        send_message(cut);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern, long hold-offs on request.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        rx_tick++;
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall = 1'b1;
        end else begin
            case (stall_mode)
                RX_READY: i_stall = 1'b0;
                RX_LIGHT: i_stall = ($urandom_range(0, 99) < 20);
                RX_HEAVY: i_stall = ($urandom_range(0, 99) < 70);
                default:  i_stall = ((rx_tick % 7) < 3);
            endcase
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t ns ERROR %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Each result taken is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_status == STATUS_FOUND) found_count++;
            else missing_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_address, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_address !== want.address)
                    report_mismatch("address", o_address, want.address);
                if (o_status !== want.status)
                    report_mismatch("status", {31'd0, o_status}, {31'd0, want.status});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("dns_response_address_parser test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Messages that end in each phase of the walk up to the address, down to a single byte,
    // and the one that ends exactly on the last address byte.
    task automatic test_truncated_messages();
        int unsigned cuts[] = '{1, 6, 13, 15, 17, 19, 25, 34, 40, 50, 51};
        sender_gaps = 1'b1;
        stall_mode  = RX_LIGHT;
        foreach (cuts[k]) begin
            build_sample_message($urandom);
            send_message(cuts[k]);
        end
        wait_for_results();
    endtask

    // Extreme addresses, bytes after the address, an unchecked data length,
    // and a second A record that must not be reported.
    task automatic test_address_found();
        sender_gaps = 1'b1;
        stall_mode  = RX_PATTERN;
        build_sample_message(32'hffff_ffff);
        put_random(5);
        send_message(0);
        build_sample_message(32'h0000_0000);
        send_message(0);
        msg.delete();
        put_random(HEADER_BYTES);
        put_label(1);
        put_question_end();
        put_a_record(32'h8000_0001, 16'd0);
        put_a_record(32'h7fff_fffe, 16'd4);
        send_message(0);
        wait_for_results();
    endtask

    // Records skipped by length: zero-length ones back to back, short ones,
    // and a type with the low byte clear.
    task automatic test_record_skipping();
        sender_gaps = 1'b0;
        stall_mode  = RX_LIGHT;
        msg.delete();
        put_random(HEADER_BYTES);
        put_label(2);
        put_question_end();
        put_record(16'h0000, 16'd0);
        put_record(16'h0005, 16'd0);
        put_record(16'h0100, 16'd3);
        put_record(16'hffff, 16'd1);
        put_a_record(32'hc0a8_0001, 16'd4);
        send_message(0);
        // No A record at all: the answers run out at the final byte.
        msg.delete();
        put_random(HEADER_BYTES);
        put_label(4);
        put_question_end();
        put_record(16'h001c, 16'd16);
        send_message(0);
        wait_for_results();
    endtask

    // The shortest label length, and a compression mark taken as a length.
    task automatic test_label_lengths();
        sender_gaps = 1'b1;
        stall_mode  = RX_HEAVY;
        msg.delete();
        put_random(HEADER_BYTES);
        put_label(1);
        put_label(8'hc0);
        put_question_end();
        put_a_record($urandom, 16'd4);
        send_message(0);
        wait_for_results();
    endtask

    // Messages one after another at full rate with no stalls.
    task automatic test_back_to_back();
        sender_gaps = 1'b0;
        stall_mode  = RX_READY;
        repeat (2) send_random_message();
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while one-byte messages keep
    // coming; each of them yields a result, so the result buffer fills and
    // the block has to stall its input.
    task automatic test_backpressure();
        sender_gaps = 1'b0;
        stall_mode  = RX_READY;
        hold_requests++;
        repeat (30) begin
            msg.delete();
            put_random(1);
            send_message(0);
        end
        build_sample_message($urandom);
        send_message(0);
        wait_for_results();
    endtask

    task automatic test_random_messages();
        int unsigned first_byte;
        int unsigned first_result;
        first_byte   = bytes_sent;
        first_result = results_seen;
        while (bytes_sent - first_byte < RANDOM_BYTES ||
               results_seen - first_result < RANDOM_RESULTS) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            stall_mode  = t_rx_mode'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0) hold_requests++;
            send_random_message();
        end
        wait_for_results();
    endtask

    initial begin
        reset_prediction();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_truncated_messages();
        test_address_found();
        test_record_skipping();
        test_label_lengths();
        test_back_to_back();
        test_backpressure();
        test_random_messages();

        $display("Covered %0d messages in %0d bytes: %0d addresses found, %0d messages without one.",
                 messages_sent, bytes_sent, found_count, missing_count);
        $display("Input stalled on %0d cycles under receiver hold-off; %0d mismatches counted.",
                 input_stalls, error_count);
        if (error_count == 0)
            $display("dns_response_address_parser test passed");
        else
            $display("dns_response_address_parser test failed");
        $finish;
    end

endmodule
